### rtl/core/lvcf_pkg.sv
// Shared types, register indexes and Q16.16 helpers for the contact force block.
// No dependencies; used by linear_viscoelastic_contact_force.
package lvcf_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STIFFNESS   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISSIPATION = 2'd1;

   // One contact
   typedef struct packed {
      logic signed [31:0] vel_p_x;
      logic signed [31:0] vel_p_y;
      logic signed [31:0] vel_p_z;
      logic signed [31:0] vel_i_x;
      logic signed [31:0] vel_i_y;
      logic signed [31:0] vel_i_z;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
      logic signed [31:0] overlap;
   } req_type;

   // One result
   typedef struct packed {
      logic signed [31:0] rel_vel_x;
      logic signed [31:0] rel_vel_y;
      logic signed [31:0] rel_vel_z;
      logic signed [31:0] normal_rel_vel;
      logic        [30:0] abs_normal_force;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic        [30:0] elastic_energy;
      logic               in_contact;
   } rsp_type;

   // Saturate a widened sum or difference to signed 32 bits
   function automatic logic signed [31:0] sat_wide(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < 36'shF_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Q16.16 product: drop 16 fraction bits (floor), then saturate to 32 bits
   function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
      logic signed [47:0] t;
      logic signed [31:0] r;
      t = p[63:16];
      if (t > 48'sh0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (t < 48'shFFFF_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = t[31:0];
      end
      return r;
   endfunction

endpackage

### rtl/core/lvcf_mul.sv
// Registered 32x32 signed multiplier, full 64-bit product, advances on enable.
// No package dependency.
module lvcf_mul (
   input  logic               clock,
   input  logic               enable,
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   output logic signed [63:0] product
);

   logic signed [63:0] product_in;
   logic signed [63:0] product_ff;

   // Exact signed product
   assign product_in = a * b;

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

### rtl/core/linear_viscoelastic_contact_force.sv
// Linear spring-dashpot contact force pipeline, top level.
// Depends on lvcf_pkg and lvcf_mul.
//
// Each accepted transaction is one contact; the block returns one result per contact, in order,
// presented from the output register, the last stage. It takes a new contact every cycle
// while the output is not stalled: the work is a seven-stage pipeline of registered 32x32
// multipliers (relative-velocity dot product, stiffness and damping terms, energy, force
// vector), and the whole pipeline holds while a finished result is stalled at the output
// register. Stiffness and dissipation are written through the csr port (index 0 and 1, low
// 31 bits of the data, other indexes ignored); write them only while no contact is in flight.
// Values are Q16.16: stiffness, dissipation, force magnitude and energy unsigned, the rest signed;
// products are floored to Q16.16 and saturated to 32 bits.
module linear_viscoelastic_contact_force (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  lvcf_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output lvcf_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lvcf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [31:0]                           csr_wdata
);

   import lvcf_pkg::*;

   localparam int NUM_STAGES = 7;

   logic advance;
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;

   logic [30:0] stiffness_ff;
   logic [30:0] dissipation_ff;

   logic signed [31:0] vel_p [3];
   logic signed [31:0] vel_i [3];
   logic signed [31:0] nrm   [3];

   // Stage payload registers
   logic signed [31:0] rv1_ff [3];
   logic signed [31:0] nv1_ff [3];
   logic               c1_ff;
   logic signed [63:0] pov1;
   logic signed [63:0] pkov1;

   logic signed [63:0] prod2 [3];
   logic signed [31:0] rv2_ff [3];
   logic signed [31:0] nv2_ff [3];
   logic signed [31:0] sq2_ff;
   logic signed [31:0] kov2_ff;
   logic               c2_ff;

   logic signed [31:0] vn3_ff;
   logic signed [31:0] vn3_in;
   logic signed [63:0] pe3;
   logic signed [31:0] rv3_ff [3];
   logic signed [31:0] nv3_ff [3];
   logic signed [31:0] kov3_ff;
   logic               c3_ff;

   logic signed [63:0] pdv4;
   logic signed [31:0] e4_q;
   logic        [30:0] e4_ff;
   logic        [30:0] e4_in;
   logic signed [31:0] vn4_ff;
   logic signed [31:0] rv4_ff [3];
   logic signed [31:0] nv4_ff [3];
   logic signed [31:0] kov4_ff;
   logic               c4_ff;

   logic signed [31:0] fn5_ff;
   logic signed [31:0] fn5_in;
   logic        [30:0] e5_ff;
   logic signed [31:0] vn5_ff;
   logic signed [31:0] rv5_ff [3];
   logic signed [31:0] nv5_ff [3];
   logic               c5_ff;

   logic signed [63:0] pf6 [3];
   logic        [30:0] mag6_ff;
   logic        [30:0] mag6_in;
   logic signed [31:0] neg5;
   logic        [30:0] e6_ff;
   logic signed [31:0] vn6_ff;
   logic signed [31:0] rv6_ff [3];
   logic               c6_ff;

   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic signed [31:0] f6_q [3];

   // Whole pipeline holds while a result is stalled at the output
   assign advance   = !(valid_ff[NUM_STAGES-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = valid_ff[NUM_STAGES-1];
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stiffness_ff   <= '0;
         dissipation_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STIFFNESS:   stiffness_ff   <= csr_wdata[30:0];
            CSR_DISSIPATION: dissipation_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // Valid bits travel with the data
   assign valid_in = {valid_ff[NUM_STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   assign vel_p[0] = req_data.vel_p_x;
   assign vel_p[1] = req_data.vel_p_y;
   assign vel_p[2] = req_data.vel_p_z;
   assign vel_i[0] = req_data.vel_i_x;
   assign vel_i[1] = req_data.vel_i_y;
   assign vel_i[2] = req_data.vel_i_z;
   assign nrm[0]   = req_data.normal_x;
   assign nrm[1]   = req_data.normal_y;
   assign nrm[2]   = req_data.normal_z;

   // Stage 1: overlap products; stage 3: energy product; stage 4: damping product
   lvcf_mul u_mul_ov (
      .clock(clock), .enable(advance),
      .a(req_data.overlap), .b(req_data.overlap), .product(pov1)
   );
   lvcf_mul u_mul_kov (
      .clock(clock), .enable(advance),
      .a({1'b0, stiffness_ff}), .b(req_data.overlap), .product(pkov1)
   );
   lvcf_mul u_mul_e (
      .clock(clock), .enable(advance),
      .a({1'b0, stiffness_ff}), .b(sq2_ff), .product(pe3)
   );
   lvcf_mul u_mul_dv (
      .clock(clock), .enable(advance),
      .a({1'b0, dissipation_ff}), .b(vn3_ff), .product(pdv4)
   );

   // Per-axis multipliers: dot product (stage 2) and force vector (stage 6)
   for (genvar j = 0; j < 3; j++) begin : g_axis
      lvcf_mul u_mul_dot (
         .clock(clock), .enable(advance),
         .a(rv1_ff[j]), .b(nv1_ff[j]), .product(prod2[j])
      );
      lvcf_mul u_mul_f (
         .clock(clock), .enable(advance),
         .a(nv5_ff[j]), .b(fn5_ff), .product(pf6[j])
      );
   end

   // Combinational work between stages
   always_comb begin
      vn3_in = sat_wide(36'(qsat(prod2[0])) + 36'(qsat(prod2[1])) + 36'(qsat(prod2[2])));
      e4_q   = qsat(pe3);
      e4_in  = e4_q[31] ? '0 : {1'b0, e4_q[30:1]};
      fn5_in = sat_wide(36'(kov4_ff) - 36'(qsat(pdv4)));
      neg5   = -fn5_ff;
      if (fn5_ff == 32'sh8000_0000) begin
         mag6_in = 31'h7FFF_FFFF;
      end else if (fn5_ff[31]) begin
         mag6_in = neg5[30:0];
      end else begin
         mag6_in = fn5_ff[30:0];
      end
   end

   // Output record; force terms are zero without contact
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         f6_q[j] = c6_ff ? qsat(pf6[j]) : '0;
      end
      rsp_in.rel_vel_x        = rv6_ff[0];
      rsp_in.rel_vel_y        = rv6_ff[1];
      rsp_in.rel_vel_z        = rv6_ff[2];
      rsp_in.normal_rel_vel   = vn6_ff;
      rsp_in.abs_normal_force = c6_ff ? mag6_ff : '0;
      rsp_in.force_x          = f6_q[0];
      rsp_in.force_y          = f6_q[1];
      rsp_in.force_z          = f6_q[2];
      rsp_in.elastic_energy   = e6_ff;
      rsp_in.in_contact       = c6_ff;
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         // stage 1: relative velocity, contact flag
         for (int j = 0; j < 3; j++) begin
            rv1_ff[j] <= sat_wide(36'(vel_p[j]) - 36'(vel_i[j]));
            nv1_ff[j] <= nrm[j];
         end
         c1_ff <= (req_data.overlap > 32'sd0);
         // stage 2: overlap square and spring term
         rv2_ff  <= rv1_ff;
         nv2_ff  <= nv1_ff;
         sq2_ff  <= qsat(pov1);
         kov2_ff <= qsat(pkov1);
         c2_ff   <= c1_ff;
         // stage 3: normal velocity
         vn3_ff  <= vn3_in;
         rv3_ff  <= rv2_ff;
         nv3_ff  <= nv2_ff;
         kov3_ff <= kov2_ff;
         c3_ff   <= c2_ff;
         // stage 4: elastic energy
         e4_ff   <= e4_in;
         vn4_ff  <= vn3_ff;
         rv4_ff  <= rv3_ff;
         nv4_ff  <= nv3_ff;
         kov4_ff <= kov3_ff;
         c4_ff   <= c3_ff;
         // stage 5: normal force
         fn5_ff  <= fn5_in;
         e5_ff   <= e4_ff;
         vn5_ff  <= vn4_ff;
         rv5_ff  <= rv4_ff;
         nv5_ff  <= nv4_ff;
         c5_ff   <= c4_ff;
         // stage 6: force magnitude
         mag6_ff <= mag6_in;
         e6_ff   <= e5_ff;
         vn6_ff  <= vn5_ff;
         rv6_ff  <= rv5_ff;
         c6_ff   <= c5_ff;
         // stage 7: output register
         rsp_ff  <= rsp_in;
      end
   end

endmodule
